// ----- design/edas_pkg.sv -----
// shared types, constants and helper functions of the escape decoding argument splitter
// no dependencies; imported by the decoder, the emitter and the core
package edas_pkg;

    // most results one input byte can cause, and the width of a count up to that
    localparam int BURST_DEPTH = 5;
    localparam int CNT_W       = $clog2(BURST_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_UPPER_X   = 8'h58;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

    // escape decoder state
    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_ESC_X  = 2'd2,
        MODE_ESC_XH = 2'd3
    } t_mode;

    // result kinds as seen on the output tuser
    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_BOUNDARY = 2'd1,
        KIND_END      = 2'd2
    } t_kind;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] x_char;
        logic [7:0] hex_digit;
    } t_esc_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_entry;

    // all results of one input byte, first result in slot zero
    typedef struct packed {
        t_entry [BURST_DEPTH-1:0] items;
        logic   [CNT_W-1:0]       count;
    } t_burst;

    function automatic logic is_hex_digit(input logic [7:0] b);
        return ((b >= CH_ZERO) && (b <= CH_NINE)) ||
               ((b >= CH_LOWER_A) && (b <= CH_LOWER_F)) ||
               ((b >= CH_UPPER_A) && (b <= CH_UPPER_F));
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
            v = b - CH_ZERO;
        end else if ((b >= CH_LOWER_A) && (b <= CH_LOWER_F)) begin
            v = b - CH_LOWER_A + HEX_ALPHA_BASE;
        end else begin
            v = b - CH_UPPER_A + HEX_ALPHA_BASE;
        end
        return v[3:0];
    endfunction

endpackage

// ----- design/edas_decoder.sv -----
// combinational escape decoder: one input byte and the current state give the
// next state and the list of results; depends on edas_pkg
module edas_decoder
    import edas_pkg::*;
(
    input  t_esc_state i_state,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_esc_state o_state,
    output t_burst     o_burst
);

    t_esc_state st;
    t_burst     bu;
    logic       do_plain;

    always_comb begin
        st       = i_state;
        bu       = '0;
        do_plain = 1'b0;

        // resolve any pending escape against this byte
        case (i_state.mode)
            MODE_ESC: begin
                st.mode = MODE_NORMAL;
                if ((i_byte == CH_BACKSLASH) || (i_byte == CH_SPACE)) begin
                    bu.items[bu.count] = '{KIND_BYTE, i_byte};
                    bu.count = bu.count + 1'b1;
                end else if ((i_byte == CH_LOWER_X) || (i_byte == CH_UPPER_X)) begin
                    st.x_char = i_byte;
                    st.mode   = MODE_ESC_X;
                end else begin
                    bu.items[bu.count] = '{KIND_BYTE, CH_BACKSLASH};
                    bu.count = bu.count + 1'b1;
                    do_plain = 1'b1;
                end
            end
            MODE_ESC_X: begin
                if (is_hex_digit(i_byte)) begin
                    st.hex_digit = i_byte;
                    st.mode      = MODE_ESC_XH;
                end else begin
                    st.mode = MODE_NORMAL;
                    bu.items[bu.count] = '{KIND_BYTE, CH_BACKSLASH};
                    bu.count = bu.count + 1'b1;
                    bu.items[bu.count] = '{KIND_BYTE, i_state.x_char};
                    bu.count = bu.count + 1'b1;
                    do_plain = 1'b1;
                end
            end
            MODE_ESC_XH: begin
                st.mode = MODE_NORMAL;
                if (is_hex_digit(i_byte)) begin
                    bu.items[bu.count] = '{KIND_BYTE,
                                           {hex_value(i_state.hex_digit), hex_value(i_byte)}};
                    bu.count = bu.count + 1'b1;
                end else begin
                    bu.items[bu.count] = '{KIND_BYTE, CH_BACKSLASH};
                    bu.count = bu.count + 1'b1;
                    bu.items[bu.count] = '{KIND_BYTE, i_state.x_char};
                    bu.count = bu.count + 1'b1;
                    bu.items[bu.count] = '{KIND_BYTE, i_state.hex_digit};
                    bu.count = bu.count + 1'b1;
                    do_plain = 1'b1;
                end
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase

        // ordinary byte handling
        if (do_plain) begin
            if (i_byte == CH_BACKSLASH) begin
                st.mode = MODE_ESC;
            end else if (i_byte == CH_SPACE) begin
                bu.items[bu.count] = '{KIND_BOUNDARY, 8'h00};
                bu.count = bu.count + 1'b1;
            end else begin
                bu.items[bu.count] = '{KIND_BYTE, i_byte};
                bu.count = bu.count + 1'b1;
            end
        end

        // end of line: flush a cut escape literally, then close the command
        if (i_end) begin
            if (st.mode != MODE_NORMAL) begin
                bu.items[bu.count] = '{KIND_BYTE, CH_BACKSLASH};
                bu.count = bu.count + 1'b1;
            end
            if ((st.mode == MODE_ESC_X) || (st.mode == MODE_ESC_XH)) begin
                bu.items[bu.count] = '{KIND_BYTE, st.x_char};
                bu.count = bu.count + 1'b1;
            end
            if (st.mode == MODE_ESC_XH) begin
                bu.items[bu.count] = '{KIND_BYTE, st.hex_digit};
                bu.count = bu.count + 1'b1;
            end
            bu.items[bu.count] = '{KIND_END, 8'h00};
            bu.count = bu.count + 1'b1;
            st.mode = MODE_NORMAL;
        end
    end

    assign o_state = st;
    assign o_burst = bu;

endmodule

// ----- design/edas_emitter.sv -----
// result buffer and output register: holds the results of one input byte and
// hands them out one transfer at a time; depends on edas_pkg
module edas_emitter
    import edas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_burst     i_burst,
    output logic       o_room,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,   // out_byte
    output logic [1:0] o_tuser,   // kind
    output logic       o_tlast    // last
);

    t_burst     r_burst;
    logic [CNT_W-1:0] r_idx;
    logic       r_valid;
    t_entry     r_out;
    logic       r_last;

    logic       busy;
    logic       move;
    logic       final_move;
    logic [CNT_W-1:0] idx_inc;

    // a buffered result moves to the output register when that one is free
    assign busy       = (r_idx != r_burst.count);
    assign move       = busy && (!r_valid || i_tready);
    assign idx_inc    = r_idx + 1'b1;
    assign final_move = move && (idx_inc == r_burst.count);
    assign o_room     = !busy || final_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst.count <= '0;
            r_idx         <= '0;
            r_valid       <= 1'b0;
        end else begin
            // output register
            if (move) begin
                r_valid <= 1'b1;
                r_out   <= r_burst.items[r_idx];
                r_last  <= (idx_inc == r_burst.count);
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
            // result buffer
            if (i_load) begin
                r_burst <= i_burst;
                r_idx   <= '0;
            end else if (move) begin
                r_idx <= idx_inc;
            end
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_out.data;
    assign o_tuser  = r_out.kind;
    assign o_tlast  = r_last;

endmodule

// ----- design/escape_decoding_argument_splitter_core.sv -----
// top level of the escape decoding argument splitter
// depends on edas_pkg, edas_decoder and edas_emitter
//
// Takes a command line as a stream of bytes, tlast on the final byte, and emits
// one result per transfer: tuser 0 with a decoded argument byte, tuser 1 at an
// argument boundary (each unescaped space), tuser 2 once after the final byte.
// Backslash-space, double backslash and backslash-x with two hex digits are
// decoded; any other or cut-off escape comes out literally. Output tlast marks
// the last result caused by one input byte. An input byte is taken every cycle
// as long as it causes at most one result and the output is ready; a byte
// causing n results (up to five, when an escape is flushed) holds the input
// while the single output register drains the result buffer one per cycle as
// the output allows. A byte that only extends a pending escape gives no result.
module escape_decoding_argument_splitter_core
    import edas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // in_byte
    input  logic       i_s_axis_tlast,   // end_of_command
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // out_byte
    output logic [1:0] o_m_axis_tuser,   // kind
    output logic       o_m_axis_tlast    // last
);

    t_esc_state r_state;
    t_esc_state n_state;
    t_burst     burst;
    logic       room;
    logic       accept;

    assign o_s_axis_tready = room;
    assign accept          = i_s_axis_tvalid && room;

    edas_decoder u_decoder (
        .i_state (r_state),
        .i_byte  (i_s_axis_tdata),
        .i_end   (i_s_axis_tlast),
        .o_state (n_state),
        .o_burst (burst)
    );

    // escape state advances on every input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{MODE_NORMAL, 8'h00, 8'h00};
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    edas_emitter u_emitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_burst  (burst),
        .o_room   (room),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule
